[src/lzwd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;
   localparam int DEF_MAX_CODE_BITS = 12;
   localparam int DEF_STACK_DEPTH   = 255;
   localparam logic [8:0] CODE_CLEAR = 9'h100;
   localparam logic [8:0] CODE_END   = 9'h101;
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_END  = 2'd2;
endpackage
`default_nettype wire

[src/lzw_variable_width_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZW variable-width decoder
// Unpacks bytes LSB-first into 9..MAX_CODE_BITS codes and decodes them as LZW.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one compressed byte per beat; req_start_of_stream restarts
//   the decoder (dictionary memory is kept) before the byte is used.
//   rsp_ channel: up to four decoded bytes per beat, last_of_code on the final
//   beat of one code, status for overflow or end code.
//   A byte that completes no code, a clear code, a literal after a clear or
//   an end code only passes through S_CODE back to S_IDLE. Per code, each
//   prefix chain step takes S_RD (dictionary read) and S_WALK (registered
//   result), each byte popped from the reversal stack takes S_POP and S_EMIT,
//   plus the code cut and the dictionary update. Chain walk and pops set
//   throughput; one byte is in work at a time. Reset returns the FSM, flags,
//   code width and accumulator to start values, not the working registers;
//   dictionary and reversal stack are not cleared and need no clearing pass.
//   A stalled receiver holds the result register; the decoder waits.
module lzw_variable_width_decoder_top
   import lzwd_pkg::*;
#(
   parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
   parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output logic             req_ready,
   input  wire  logic [7:0] req_data_byte,
   input  wire  logic       req_start_of_stream,
   output logic             rsp_valid,
   input  wire  logic       rsp_ready,
   output logic [7:0]       rsp_out_byte0,
   output logic [7:0]       rsp_out_byte1,
   output logic [7:0]       rsp_out_byte2,
   output logic [7:0]       rsp_out_byte3,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_last_of_code,
   output logic [1:0]       rsp_status
);
   localparam int CW  = MAX_CODE_BITS;
   localparam int NW  = CW + 1;
   localparam int DSZ = 1 << CW;
   localparam int SW  = $clog2(STACK_DEPTH + 1);
   localparam int WW  = $clog2(CW + 1);
   localparam int AW  = CW + 8;
   localparam int HW  = $clog2(AW + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_CODE = 7'b0000010,
      S_RD   = 7'b0000100,
      S_WALK = 7'b0001000,
      S_POP  = 7'b0010000,
      S_EMIT = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // dictionary and reversal stack memories
   logic [CW-1:0] prefix_mem [DSZ];
   logic [7:0]    suffix_mem [DSZ];
   logic [7:0]    stack_mem  [STACK_DEPTH];
   logic [CW-1:0] pre_rd_ff;
   logic [7:0]    suf_rd_ff, stk_rd_ff;
   logic          dict_we;
   logic [CW-1:0] dict_wa, dict_ra, dict_wp;
   logic [7:0]    dict_ws;
   logic          stk_we;
   logic [SW-1:0] stk_wa, stk_ra;
   logic [7:0]    stk_wd;

   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_wa] <= dict_wp;
         suffix_mem[dict_wa] <= dict_ws;
      end
      pre_rd_ff <= prefix_mem[dict_ra];
      suf_rd_ff <= suffix_mem[dict_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stack_mem[stk_ra];
   end

   // decoder control state
   logic [NW-1:0] next_free_ff, next_free_in, limit_ff, limit_in;
   logic [WW-1:0] width_ff, width_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [HW-1:0] held_ff, held_in;
   logic [CW-1:0] prev_ff, prev_in, code_ff, code_in, cur_ff, cur_in;
   logic [7:0]    pfc_ff, pfc_in, first_ff, first_in;
   logic          clr_ff, clr_in, stop_ff, stop_in;
   logic [SW-1:0] depth_ff, depth_in;
   logic [2:0]    n_ff, n_in;
   logic          rv_ff, rv_in;
   logic [7:0]    ob_ff [4];
   logic [7:0]    ob_in [4];
   logic [2:0]    cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic [1:0]    st_ff, st_in;

   logic [AW-1:0] acc_new;
   logic [HW-1:0] held_new;
   logic [CW-1:0] code_mask;
   logic [CW-1:0] code_cut;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_out_byte0 = ob_ff[0];
   assign rsp_out_byte1 = ob_ff[1];
   assign rsp_out_byte2 = ob_ff[2];
   assign rsp_out_byte3 = ob_ff[3];
   assign rsp_byte_count = cnt_ff;
   assign rsp_last_of_code = last_ff;
   assign rsp_status = st_ff;

   always_comb begin
      code_mask = CW'((CW'(1) << width_ff) - CW'(1));
      code_cut  = acc_ff[CW-1:0] & code_mask;
   end

   always_comb begin
      state_in = state_ff;
      next_free_in = next_free_ff; limit_in = limit_ff; width_in = width_ff;
      acc_in = acc_ff; held_in = held_ff; prev_in = prev_ff; pfc_in = pfc_ff;
      clr_in = clr_ff; stop_in = stop_ff; code_in = code_ff; cur_in = cur_ff;
      first_in = first_ff; depth_in = depth_ff; n_in = n_ff;
      rv_in = rv_ff; ob_in = ob_ff; cnt_in = cnt_ff; last_in = last_ff;
      st_in = st_ff;
      dict_we = 1'b0; dict_wa = next_free_ff[CW-1:0];
      dict_wp = prev_ff; dict_ws = first_ff; dict_ra = cur_ff;
      stk_we = 1'b0; stk_wa = depth_ff; stk_wd = suf_rd_ff;
      stk_ra = SW'(depth_ff - SW'(1));
      acc_new = '0; held_new = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_start_of_stream) begin
                  acc_new = AW'(req_data_byte);
                  held_new = HW'(8);
                  next_free_in = NW'(258); limit_in = NW'(512);
                  width_in = WW'(9); prev_in = '0; pfc_in = '0;
                  clr_in = 1'b0; stop_in = 1'b0;
                  acc_in = acc_new; held_in = held_new;
                  state_in = S_CODE;
               end else if (!stop_ff) begin
                  acc_new = acc_ff | (AW'(req_data_byte) << held_ff);
                  held_new = HW'(held_ff + HW'(8));
                  acc_in = acc_new; held_in = held_new;
                  state_in = S_CODE;
               end
            end
         end
         S_CODE: begin
            // cut one code if enough bits are held
            if (held_ff < HW'(width_ff)) begin
               state_in = S_IDLE;
            end else if (!rv_ff || rsp_ready) begin
               acc_in = acc_ff >> width_ff;
               held_in = HW'(held_ff - HW'(width_ff));
               code_in = code_cut;
               depth_in = '0;
               state_in = S_IDLE;
               if (clr_ff) begin
                  clr_in = 1'b0; prev_in = code_cut; pfc_in = code_cut[7:0];
                  rv_in = 1'b1; ob_in = '{code_cut[7:0], 8'd0, 8'd0, 8'd0};
                  cnt_in = 3'd1; last_in = 1'b1; st_in = ST_OK;
               end else if (code_cut == CW'(CODE_END)) begin
                  stop_in = 1'b1; rv_in = 1'b1; ob_in = '{default: 8'd0};
                  cnt_in = 3'd0; last_in = 1'b1; st_in = ST_END;
               end else if (code_cut == CW'(CODE_CLEAR)) begin
                  width_in = WW'(9); limit_in = NW'(512);
                  next_free_in = NW'(258); clr_in = 1'b1;
               end else if (NW'(code_cut) >= next_free_ff) begin
                  stk_we = 1'b1; stk_wa = '0; stk_wd = pfc_ff;
                  depth_in = SW'(1); cur_in = prev_ff; state_in = S_RD;
               end else begin
                  cur_in = code_cut; state_in = S_RD;
               end
            end
         end
         S_RD: begin
            // issue a dictionary read for cur, or finish the walk
            if (cur_ff <= CW'(255)) begin
               if (depth_ff >= SW'(STACK_DEPTH)) begin
                  state_in = S_FIN; st_in = ST_OVF;
               end else begin
                  stk_we = 1'b1; stk_wd = cur_ff[7:0];
                  first_in = cur_ff[7:0];
                  depth_in = SW'(depth_ff + SW'(1));
                  n_in = 3'd0; state_in = S_POP;
               end
            end else if (depth_ff >= SW'(STACK_DEPTH)) begin
               state_in = S_FIN; st_in = ST_OVF;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            stk_we = 1'b1; stk_wd = suf_rd_ff;
            depth_in = SW'(depth_ff + SW'(1));
            cur_in = pre_rd_ff; state_in = S_RD;
         end
         S_POP: begin
            // stack read issued this cycle lands next cycle in stk_rd_ff
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               // a new beat starts with all byte lanes at zero
               if (n_ff == 3'd0) ob_in = '{default: 8'd0};
               ob_in[n_ff[1:0]] = stk_rd_ff;
               depth_in = SW'(depth_ff - SW'(1));
               if (depth_ff == SW'(1) || n_ff == 3'd3) begin
                  rv_in = 1'b1; cnt_in = 3'(n_ff + 3'd1);
                  last_in = (depth_ff == SW'(1)); st_in = ST_OK;
                  n_in = 3'd0;
                  if (depth_ff == SW'(1)) begin
                     state_in = S_FIN;
                  end else begin
                     stk_ra = SW'(depth_ff - SW'(2));
                     state_in = S_POP;
                  end
               end else begin
                  n_in = 3'(n_ff + 3'd1);
                  stk_ra = SW'(depth_ff - SW'(2));
                  state_in = S_POP;
               end
            end
         end
         S_FIN: begin
            if (st_ff == ST_OVF) begin
               if (!rv_ff || rsp_ready) begin
                  stop_in = 1'b1; rv_in = 1'b1; ob_in = '{default: 8'd0};
                  cnt_in = 3'd0; last_in = 1'b1; st_in = ST_OVF;
                  state_in = S_IDLE;
               end
            end else begin
               // dictionary update and width growth
               if (next_free_ff < NW'(DSZ)) begin
                  dict_we = 1'b1; dict_ws = first_ff; dict_wp = prev_ff;
                  next_free_in = NW'(next_free_ff + NW'(1));
               end
               prev_in = code_ff; pfc_in = first_ff;
               if (next_free_in >= limit_ff && width_ff < WW'(CW)) begin
                  width_in = WW'(width_ff + WW'(1));
                  limit_in = NW'(limit_ff << 1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0;
         next_free_ff <= NW'(258); limit_ff <= NW'(512); width_ff <= WW'(9);
         acc_ff <= '0; held_ff <= '0; prev_ff <= '0; pfc_ff <= '0;
         clr_ff <= 1'b0; stop_ff <= 1'b0; st_ff <= ST_OK;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in;
         next_free_ff <= next_free_in; limit_ff <= limit_in; width_ff <= width_in;
         acc_ff <= acc_in; held_ff <= held_in; prev_ff <= prev_in;
         pfc_ff <= pfc_in; clr_ff <= clr_in; stop_ff <= stop_in; st_ff <= st_in;
      end
      code_ff <= code_in; cur_ff <= cur_in; first_ff <= first_in;
      depth_ff <= depth_in; n_ff <= n_in; ob_ff <= ob_in;
      cnt_ff <= cnt_in; last_ff <= last_in;
   end

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_start_of_stream || !stop_ff)) |=> !req_ready)
      else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_byte_count)))
      else $error("result dropped");
   a_width: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= WW'(9)) && (width_ff <= WW'(CW)))
      else $error("code width out of range");
endmodule
`default_nettype wire

[bench/lzw_variable_width_decoder_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW variable-width decoder testbench
// Packs LZW code streams into bytes, drives them with random valid/ready
// gaps and checks every response beat against a code-level decoder model.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_top_tb;
   import lzwd_pkg::*;

   localparam int DICT_SIZE  = 4096;
   localparam int MAX_DEPTH  = 255;
   localparam int FIRST_FREE = 'h102;
   localparam int WDOG_LIMIT = 4000;

   typedef struct {
      logic [7:0] b0, b1, b2, b3;
      logic [2:0] cnt;
      logic       last;
      logic [1:0] st;
   } word_type;

   typedef struct {
      logic [7:0] data;
      logic       sos;
   } byte_beat_type;

   typedef struct {
      bit         sos;
      int         code;
      bit         typed;
      logic [7:0] b0;
      logic [2:0] cnt;
      logic [1:0] st;
   } dir_row_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic [7:0] req_data_byte = 0;
   logic       req_start_of_stream = 0;
   logic       rsp_ready = 0;
   logic       req_ready, rsp_valid, rsp_last_of_code;
   logic [7:0] rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3;
   logic [2:0] rsp_byte_count;
   logic [1:0] rsp_status;

   lzw_variable_width_decoder_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_start_of_stream(req_start_of_stream),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte0(rsp_out_byte0), .rsp_out_byte1(rsp_out_byte1),
      .rsp_out_byte2(rsp_out_byte2), .rsp_out_byte3(rsp_out_byte3),
      .rsp_byte_count(rsp_byte_count), .rsp_last_of_code(rsp_last_of_code),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // decoder model state
   logic [11:0] pfx_mem [DICT_SIZE];
   logic [7:0]  sfx_mem [DICT_SIZE];
   bit          written  [DICT_SIZE];
   int          next_free, width_lim, code_w, prev_code;
   logic [7:0]  prev_first;
   bit          clear_pend, halted;

   word_type      decoded_words[$];
   byte_beat_type byte_stream[$];

   // bit packer
   logic [31:0] bit_buf;
   int          bit_cnt;
   bit          sos_pend;

   int fails = 0;
   int cyc = 0;
   int idle_cyc = 0;

   function automatic void push_word(logic [7:0] g[4], int n, bit last, logic [1:0] st);
      word_type w;
      w.b0 = n > 0 ? g[0] : 8'h00;
      w.b1 = n > 1 ? g[1] : 8'h00;
      w.b2 = n > 2 ? g[2] : 8'h00;
      w.b3 = n > 3 ? g[3] : 8'h00;
      w.cnt = n[2:0];
      w.last = last;
      w.st = st;
      decoded_words.insert(decoded_words.size(), w);
   endfunction

   // Decode one code, append its response beats
   function automatic void lzw_decode_code(int code);
      logic [7:0] stk [256];
      logic [7:0] grp [4];
      logic [7:0] first;
      int depth, cur, n;
      depth = 0;
      cur = code;
      grp = '{8'h0, 8'h0, 8'h0, 8'h0};
      if (clear_pend) begin
         clear_pend = 0;
         prev_code = code;
         prev_first = code[7:0];
         grp[0] = prev_first;
         push_word(grp, 1, 1, ST_OK);
         return;
      end
      if (code == CODE_END) begin
         halted = 1;
         push_word(grp, 0, 1, ST_END);
         return;
      end
      if (code == CODE_CLEAR) begin
         code_w = 9;
         width_lim = 'h200;
         next_free = FIRST_FREE;
         clear_pend = 1;
         return;
      end
      if (code >= next_free) begin
         stk[depth] = prev_first;
         depth++;
         cur = prev_code;
      end
      // prefix chain walk
      while (cur > 'hFF && depth < MAX_DEPTH) begin
         cur = cur & (DICT_SIZE - 1);
         stk[depth] = sfx_mem[cur];
         depth++;
         cur = pfx_mem[cur];
      end
      if (depth >= MAX_DEPTH) begin
         halted = 1;
         push_word(grp, 0, 1, ST_OVF);
         return;
      end
      first = cur[7:0];
      stk[depth] = first;
      depth++;
      while (depth > 0) begin
         n = 0;
         while (n < 4 && depth > 0) begin
            depth--;
            grp[n] = stk[depth];
            n++;
         end
         push_word(grp, n, depth == 0, ST_OK);
      end
      if (next_free < DICT_SIZE) begin
         pfx_mem[next_free] = prev_code[11:0];
         sfx_mem[next_free] = first;
         written[next_free] = 1;
         next_free++;
      end
      prev_code = code;
      prev_first = first;
      if (next_free >= width_lim && code_w < DEF_MAX_CODE_BITS) begin
         code_w++;
         width_lim = width_lim << 1;
      end
   endfunction

   // true when decoding walks only written dictionary entries
   function automatic bit chain_known(int c);
      int steps;
      steps = 0;
      while (c > 'hFF && steps < 300) begin
         if (!written[c & (DICT_SIZE - 1)]) return 0;
         c = pfx_mem[c & (DICT_SIZE - 1)];
         steps++;
      end
      return 1;
   endfunction

   function automatic bit code_safe(int c);
      if (clear_pend || c == CODE_END || c == CODE_CLEAR) return 1;
      return c >= next_free ? chain_known(prev_code) : chain_known(c);
   endfunction

   function automatic void push_byte(logic [7:0] d);
      byte_beat_type b;
      b.data = d;
      b.sos = sos_pend;
      sos_pend = 0;
      byte_stream.insert(byte_stream.size(), b);
   endfunction

   // pack a code at the current width, then decode it unless stopped
   function automatic void send_code(int c);
      bit_buf = bit_buf | (32'(c) << bit_cnt);
      bit_cnt += code_w;
      while (bit_cnt >= 8) begin
         push_byte(bit_buf[7:0]);
         bit_buf = bit_buf >> 8;
         bit_cnt -= 8;
      end
      if (!halted) lzw_decode_code(c);
   endfunction

   // pad out the partial byte, add ignored bytes after a stop, restart
   function automatic void new_stream();
      logic [7:0] pad;
      if (bit_cnt > 0) begin
         pad = $urandom;
         push_byte((pad << bit_cnt) | bit_buf[7:0]);
      end
      if (halted)
         repeat ($urandom_range(2, 0)) push_byte($urandom);
      bit_buf = 0;
      bit_cnt = 0;
      sos_pend = 1;
      next_free = FIRST_FREE;
      width_lim = 'h200;
      code_w = 9;
      prev_code = 0;
      prev_first = 0;
      clear_pend = 0;
      halted = 0;
   endfunction

   function automatic int pick_code();
      int r, maxc, c;
      maxc = (1 << code_w) - 1;
      r = $urandom_range(99);
      if (clear_pend)
         c = r < 10 ? $urandom_range('h1FF, 'h100) : $urandom_range(255);
      else if (r < 40)
         c = $urandom_range(255);
      else if (r < 60 && next_free > FIRST_FREE)
         c = $urandom_range(next_free - 1, FIRST_FREE);
      else if (r < 75 && next_free <= maxc)
         c = next_free;
      else if (r < 85 && next_free <= maxc)
         c = $urandom_range(maxc, next_free);
      else if (r < 91)
         c = CODE_CLEAR;
      else if (r < 94)
         c = CODE_END;
      else
         c = $urandom_range(255);
      return code_safe(c) ? c : int'(CODE_CLEAR);
   endfunction

   dir_row_type dir_tab[16] = '{
      '{1, 'h041, 1, 8'h41, 3'd1, ST_OK},
      '{0, 'h042, 1, 8'h42, 3'd1, ST_OK},
      '{0, 'h102, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h104, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h1FF, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h100, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h1C3, 1, 8'hC3, 3'd1, ST_OK},
      '{0, 'h100, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h100, 1, 8'h00, 3'd1, ST_OK},
      '{0, 'h100, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h101, 1, 8'h01, 3'd1, ST_OK},
      '{0, 'h100, 0, 8'h00, 3'd0, ST_OK},
      '{0, 'h0FF, 1, 8'hFF, 3'd1, ST_OK},
      '{0, 'h000, 1, 8'h00, 3'd1, ST_OK},
      '{0, 'h101, 1, 8'h00, 3'd0, ST_END},
      '{1, 'h101, 1, 8'h00, 3'd0, ST_END}
   };

   // Build the whole byte stream and its decoded words up front
   task automatic build_stimulus();
      word_type tw;
      int       ncodes;
      bit_buf = 0;
      bit_cnt = 0;
      foreach (written[i]) written[i] = 0;
      new_stream();
      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].sos && i > 0) new_stream();
         send_code(dir_tab[i].code);
         if (dir_tab[i].typed) begin
            void'(decoded_words.pop_back());
            tw = '{dir_tab[i].b0, 8'h0, 8'h0, 8'h0, dir_tab[i].cnt, 1'b1, dir_tab[i].st};
            decoded_words.insert(decoded_words.size(), tw);
         end
      end
      // string grows by one byte per code until it overflows the stack
      new_stream();
      send_code($urandom_range(255));
      while (!halted) send_code(next_free);
      // random streams up to the item budget
      while (byte_stream.size() < 465) begin
         new_stream();
         ncodes = $urandom_range(60, 5);
         repeat (ncodes) if (!halted) send_code(pick_code());
      end
      new_stream();
   endtask

   // request driver
   always @(posedge clock) begin
      byte_beat_type b;
      cyc <= cyc + 1;
      if (!reset && (!req_valid || req_ready)) begin
         if (byte_stream.size() > 0 &&
             ((cyc >= 3000 && cyc < 8000) || $urandom_range(99) >= 25)) begin
            b = byte_stream.pop_front();
            req_valid <= 1;
            req_data_byte <= b.data;
            req_start_of_stream <= b.sos;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response ready
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 0;
      else
         rsp_ready <= (cyc >= 3000 && cyc < 8000) || $urandom_range(99) >= 25;
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fails++;
      end
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      word_type w;
      if (rsp_valid && rsp_ready && !reset) begin
         if (decoded_words.size() == 0) begin
            $error("unexpected response beat");
            fails++;
         end else begin
            w = decoded_words.pop_front();
            check_field("out_byte0", w.b0, rsp_out_byte0);
            check_field("out_byte1", w.b1, rsp_out_byte1);
            check_field("out_byte2", w.b2, rsp_out_byte2);
            check_field("out_byte3", w.b3, rsp_out_byte3);
            check_field("byte_count", w.cnt, rsp_byte_count);
            check_field("last_of_code", w.last, rsp_last_of_code);
            check_field("status", w.st, rsp_status);
         end
      end
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || reset)
         idle_cyc <= 0;
      else
         idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WDOG_LIMIT) begin
         $display("** lzw_variable_width_decoder_top: FAILED **");
         $finish;
      end
   end

   // sequence: build, reset, drain, verdict
   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 0;
      while (byte_stream.size() > 0 || req_valid || decoded_words.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (fails == 0 && decoded_words.size() == 0)
         $display("** lzw_variable_width_decoder_top: PASSED **");
      else
         $display("** lzw_variable_width_decoder_top: FAILED **");
      $finish;
   end
endmodule
